@@ hdl/rhc_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

  localparam int CH_W      = 8;   // one color channel
  localparam int HUE_W     = 16;
  localparam int SAT_W     = 16;
  localparam int QUO_W     = 16;  // quotient bits of both dividers
  localparam int SAT_NUM_W = 24;  // delta * 65535 < 2**24
  localparam int HUE_NUM_W = 20;  // 3840 * 255 < 2**20
  localparam int HUE_MAG_W = 13;  // rounded sector offset, at most 3840

  localparam logic signed [HUE_W-1:0] HUE_BASE_RED   = 16'sd0;
  localparam logic signed [HUE_W-1:0] HUE_BASE_GREEN = 16'sd7680;
  localparam logic signed [HUE_W-1:0] HUE_BASE_BLUE  = 16'sd15360;
  localparam logic signed [HUE_W-1:0] HUE_FULL       = 16'sd23040;
  localparam logic signed [HUE_W-1:0] HUE_NONE       = -16'sd1;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_t;

  typedef struct packed {
    rhc_sector_t sector;  // which channel is the largest
    logic        neg;     // sector difference is negative
    logic        none;    // grey or black, hue undefined
  } rhc_tag_t;

  typedef struct packed {
    rhc_tag_t                tag;
    logic [CH_W-1:0]         brightness;
    logic [SAT_NUM_W-1:0]    sat_num;
    logic [CH_W-1:0]         sat_den;
    logic [HUE_NUM_W-1:0]    hue_num;
    logic [CH_W-1:0]         hue_den;
  } rhc_front_t;

endpackage

@@ hdl/rhc_if.sv @@
// Valid/ready channel interfaces for pixels in and HSV words out.
interface rhc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::CH_W-1:0]  red;
  logic [rhc_pkg::CH_W-1:0]  green;
  logic [rhc_pkg::CH_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
  logic                              valid;
  logic                              ready;
  logic signed [rhc_pkg::HUE_W-1:0]  hue;
  logic [rhc_pkg::SAT_W-1:0]         saturation;
  logic [rhc_pkg::CH_W-1:0]          brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

@@ hdl/rhc_front.sv @@
// Front end: channel max/min, sector choice and division operands, two stages.
module rhc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rhc_pkg::CH_W-1:0]    red,
  input  logic [rhc_pkg::CH_W-1:0]    green,
  input  logic [rhc_pkg::CH_W-1:0]    blue,
  output logic                        out_valid,
  output rhc_pkg::rhc_front_t         out_data
);

  logic [rhc_pkg::CH_W-1:0] mx_c, mn_c, da_c, db_c;
  rhc_pkg::rhc_sector_t     sec_c;

  logic                     a_valid;
  logic [rhc_pkg::CH_W-1:0] a_max, a_delta, a_mag;
  rhc_pkg::rhc_tag_t        a_tag;

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    // Ties go to red, then green.
    priority if (red >= green && red >= blue) begin
      sec_c = rhc_pkg::SEC_RED;
      da_c  = green;
      db_c  = blue;
    end else if (green >= blue) begin
      sec_c = rhc_pkg::SEC_GREEN;
      da_c  = blue;
      db_c  = red;
    end else begin
      sec_c = rhc_pkg::SEC_BLUE;
      da_c  = red;
      db_c  = green;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
    if (en) begin
      a_max      <= mx_c;
      a_delta    <= mx_c - mn_c;
      a_tag.sector <= sec_c;
      a_tag.neg  <= da_c < db_c;
      a_tag.none <= mx_c == mn_c;
      a_mag      <= (da_c < db_c) ? db_c - da_c : da_c - db_c;
      // delta * 65535 and magnitude * 3840 by shift and subtract.
      out_data.tag        <= a_tag;
      out_data.brightness <= a_max;
      out_data.sat_num    <= {a_delta, 16'h0000} - {16'h0000, a_delta};
      out_data.sat_den    <= a_max;
      out_data.hue_num    <= {a_mag, 12'h000} - {4'h0, a_mag, 8'h00};
      out_data.hue_den    <= a_delta;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (en && a_valid && !a_tag.none) |=> (out_data.sat_num != '0))
    else $error("nonzero delta gave a zero saturation numerator");

endmodule

@@ hdl/rhc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rhc_div #(
  parameter int NW = 24,  // numerator width
  parameter int QW = 16,  // quotient width, numerator < den * 2**QW
  parameter int DW = 8,   // divisor width
  parameter int SW = 8    // sideband width
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [NW-1:0] rem,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld [QW+1];
  logic [NW-1:0] r   [QW+1];
  logic [DW-1:0] d   [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [SW-1:0] sb  [QW+1];

  assign vld[0] = in_valid;
  assign r[0]   = num;
  assign d[0]   = den;
  assign q[0]   = '0;
  assign sb[0]  = side_in;

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int B = QW - 1 - s;
    logic [CW-1:0] r_ext, trial, diff;
    logic          ge;
    logic [QW-1:0] q_set;

    always_comb begin
      r_ext    = CW'(r[s]);
      trial    = CW'(d[s]) << B;
      ge       = r_ext >= trial;
      diff     = r_ext - trial;
      q_set    = q[s];
      q_set[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        r[s+1]  <= ge ? diff[NW-1:0] : r[s];
        d[s+1]  <= d[s];
        q[s+1]  <= q_set;
        sb[s+1] <= sb[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign rem       = r[QW];
  assign side_out  = sb[QW];

  assert property (@(posedge clk) disable iff (rst)
                   (vld[QW] && d[QW] != '0) |-> (CW'(r[QW]) < CW'(d[QW])))
    else $error("divider remainder not below divisor");

endmodule

@@ hdl/rhc_back.sv @@
// Back end: hue rounding, sector base, wrap and the grey special case.
module rhc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [rhc_pkg::QUO_W-1:0]          hue_quo,
  input  logic [rhc_pkg::HUE_NUM_W-1:0]      hue_rem,
  input  rhc_pkg::rhc_tag_t                  tag,
  input  logic [rhc_pkg::QUO_W-1:0]          sat_quo,
  input  logic [rhc_pkg::CH_W-1:0]           brightness_in,
  output logic                               out_valid,
  output logic signed [rhc_pkg::HUE_W-1:0]   hue,
  output logic [rhc_pkg::SAT_W-1:0]          saturation,
  output logic [rhc_pkg::CH_W-1:0]           brightness
);

  logic [rhc_pkg::HUE_MAG_W-1:0]      mag_c;
  logic signed [rhc_pkg::HUE_W-1:0]   base_c, raw_c;

  logic                               b_valid, b_none;
  logic signed [rhc_pkg::HUE_W-1:0]   b_raw;
  logic [rhc_pkg::SAT_W-1:0]          b_sat;
  logic [rhc_pkg::CH_W-1:0]           b_bright;

  always_comb begin
    // A negative difference rounds toward minus infinity: bump the magnitude.
    mag_c = {1'b0, hue_quo[rhc_pkg::HUE_MAG_W-2:0]}
          + rhc_pkg::HUE_MAG_W'(tag.neg && hue_rem != '0);
    unique case (tag.sector)
      rhc_pkg::SEC_RED:   base_c = rhc_pkg::HUE_BASE_RED;
      rhc_pkg::SEC_GREEN: base_c = rhc_pkg::HUE_BASE_GREEN;
      rhc_pkg::SEC_BLUE:  base_c = rhc_pkg::HUE_BASE_BLUE;
      default:            base_c = rhc_pkg::HUE_BASE_RED;
    endcase
    raw_c = tag.neg ? base_c - signed'(rhc_pkg::HUE_W'(mag_c))
                    : base_c + signed'(rhc_pkg::HUE_W'(mag_c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= in_valid;
      out_valid <= b_valid;
    end
    if (en) begin
      b_raw      <= raw_c;
      b_none     <= tag.none;
      b_sat      <= sat_quo;
      b_bright   <= brightness_in;
      brightness <= b_bright;
      saturation <= b_none ? '0 : b_sat;
      if (b_none) begin
        hue <= rhc_pkg::HUE_NONE;
      end else if (b_raw < 0) begin
        hue <= b_raw + rhc_pkg::HUE_FULL;
      end else begin
        hue <= b_raw;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (in_valid && !tag.none) |->
                   (hue_quo[rhc_pkg::QUO_W-1:rhc_pkg::HUE_MAG_W-1] == '0))
    else $error("hue quotient exceeds one sector");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && hue != rhc_pkg::HUE_NONE) |->
                   (hue >= 0 && hue < rhc_pkg::HUE_FULL))
    else $error("hue outside the circle");

endmodule

@@ hdl/rgb_to_hsv_converter_unit.sv @@
// Top level of the pipelined RGB to HSV converter.
//
//  channel | dir | word fields                          | handshake
//  pix     | in  | red, green, blue (8 bits each)       | valid/ready
//  hsv     | out | hue (s16), saturation (16), bright(8)| valid/ready
//
// One pixel enters per clock while the output is not stalled; the stages
// are two front stages, sixteen divider stages (one quotient bit each, hue
// and saturation side by side), and two back stages, the last of which is
// the output register. The divider pipelines hold one pixel per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline with one shared enable, so
// no word is lost or repeated; ready to the source is low only while the
// output register holds a word that the sink has not taken.
module rgb_to_hsv_converter_unit (
  input  logic            clk,
  input  logic            rst,
  rhc_pix_if.sink         pix,
  rhc_hsv_if.source       hsv
);

  // Advance everything unless the output register is full and stalled.
  logic en;
  assign en        = !hsv.valid || hsv.ready;
  assign pix.ready = en;

  logic                 f_valid;
  rhc_pkg::rhc_front_t  f_data;

  rhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pix.valid),
    .red      (pix.red),
    .green    (pix.green),
    .blue     (pix.blue),
    .out_valid(f_valid),
    .out_data (f_data)
  );

  // Saturation: floor(delta * 65535 / max); the brightness rides along.
  logic                          s_valid;
  logic [rhc_pkg::QUO_W-1:0]     s_quo;
  logic [rhc_pkg::SAT_NUM_W-1:0] s_rem;
  logic [rhc_pkg::CH_W-1:0]      s_bright;

  rhc_div #(
    .NW(rhc_pkg::SAT_NUM_W),
    .QW(rhc_pkg::QUO_W),
    .DW(rhc_pkg::CH_W),
    .SW(rhc_pkg::CH_W)
  ) u_sat_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .num      (f_data.sat_num),
    .den      (f_data.sat_den),
    .side_in  (f_data.brightness),
    .out_valid(s_valid),
    .quo      (s_quo),
    .rem      (s_rem),
    .side_out (s_bright)
  );

  // Hue offset inside the sector: 3840 * |diff| / delta, remainder kept
  // so the back end can round negative differences down.
  logic                          h_valid;
  logic [rhc_pkg::QUO_W-1:0]     h_quo;
  logic [rhc_pkg::HUE_NUM_W-1:0] h_rem;
  logic [$bits(rhc_pkg::rhc_tag_t)-1:0] h_side;
  rhc_pkg::rhc_tag_t             h_tag;

  rhc_div #(
    .NW(rhc_pkg::HUE_NUM_W),
    .QW(rhc_pkg::QUO_W),
    .DW(rhc_pkg::CH_W),
    .SW($bits(rhc_pkg::rhc_tag_t))
  ) u_hue_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .num      (f_data.hue_num),
    .den      (f_data.hue_den),
    .side_in  (f_data.tag),
    .out_valid(h_valid),
    .quo      (h_quo),
    .rem      (h_rem),
    .side_out (h_side)
  );

  assign h_tag = rhc_pkg::rhc_tag_t'(h_side);

  rhc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (h_valid && s_valid),
    .hue_quo      (h_quo),
    .hue_rem      (h_rem),
    .tag          (h_tag),
    .sat_quo      (s_quo),
    .brightness_in(s_bright),
    .out_valid    (hsv.valid),
    .hue          (hsv.hue),
    .saturation   (hsv.saturation),
    .brightness   (hsv.brightness)
  );

  // Both dividers see the same valid stream, so they must stay in step.
  assert property (@(posedge clk) disable iff (rst) h_valid == s_valid)
    else $error("hue and saturation dividers out of step");

  // A colored pixel always has saturation of at least 257, so zero
  // saturation only appears together with the undefined hue.
  assert property (@(posedge clk) disable iff (rst)
                   (hsv.valid && hsv.saturation == '0) |->
                   (hsv.hue == rhc_pkg::HUE_NONE))
    else $error("zero saturation with a defined hue");

  // A black pixel has no hue and zero saturation.
  assert property (@(posedge clk) disable iff (rst)
                   (hsv.valid && hsv.brightness == '0) |->
                   (hsv.hue == rhc_pkg::HUE_NONE && hsv.saturation == '0))
    else $error("black pixel with hue or saturation");

  // The saturation remainder is only inspected by the divider checks.
  assert property (@(posedge clk) disable iff (rst)
                   (s_valid && s_bright != '0) |->
                   (s_rem < rhc_pkg::SAT_NUM_W'(s_bright)))
    else $error("saturation remainder not below brightness");

endmodule
